>>> rtl/core/midi_chord_arpeggiator_unit_defines.svh
// Assertion macros used by the checker file of the chord arpeggiator.
// Depends on nothing; included by the checker module.
`ifndef MIDI_CHORD_ARPEGGIATOR_UNIT_DEFINES_SVH
`define MIDI_CHORD_ARPEGGIATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define MCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

>>> rtl/core/mca_pkg.sv
// Package of the chord arpeggiator: widths, codes, chord tables and the
// structs passed between its modules. Depends on nothing.
package mca_pkg;

    localparam int KEY_W         = 7;
    localparam int VEL_W         = 7;
    localparam int TIME_W        = 32;
    localparam int QUAL_W        = 4;
    localparam int OFFS_W        = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CHORD_TONES   = 4;
    localparam int IDX_W         = 2;
    localparam int COUNT_W       = 3;
    localparam int INTV_W        = 4;
    localparam int NUM_QUALITIES = 10;
    localparam int ONSET_STEP    = 100;
    localparam int DUR_FIRST     = 600;

    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_QUALITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMING_OFFSET = 2'd1;

    localparam logic [QUAL_W-1:0] Q_DIM     = 4'd0;
    localparam logic [QUAL_W-1:0] Q_MIN     = 4'd1;
    localparam logic [QUAL_W-1:0] Q_MAJ     = 4'd2;
    localparam logic [QUAL_W-1:0] Q_AUG     = 4'd3;
    localparam logic [QUAL_W-1:0] Q_FULLDIM = 4'd4;
    localparam logic [QUAL_W-1:0] Q_HALFDIM = 4'd5;
    localparam logic [QUAL_W-1:0] Q_MM7     = 4'd6;
    localparam logic [QUAL_W-1:0] Q_MMAJ7   = 4'd7;
    localparam logic [QUAL_W-1:0] Q_DOM7    = 4'd8;
    localparam logic [QUAL_W-1:0] Q_MAJ7    = 4'd9;

    // Operand set for the shared adder/subtractor.
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
    } alu_op_t;

    // Write commands into the tone parameter store.
    typedef struct packed {
        logic              rec_we;
        logic [IDX_W-1:0]  rec_idx;
        logic [TIME_W-1:0] rec_onset;
        logic [KEY_W-1:0]  rec_key;
        logic [VEL_W-1:0]  rec_attack;
        logic              off_we;
        logic [IDX_W-1:0]  off_idx;
        logic [TIME_W-1:0] off_dur;
        logic              fin_clr;
    } store_wr_t;

    // Read data of the tone parameter store at one address.
    typedef struct packed {
        logic [TIME_W-1:0] onset;
        logic [TIME_W-1:0] dur;
        logic [VEL_W-1:0]  attack;
    } store_rd_t;

    function automatic logic [INTV_W-1:0] interval_of(input logic [QUAL_W-1:0] q,
                                                      input logic [IDX_W-1:0]  i);
        logic [INTV_W-1:0] third;
        logic [INTV_W-1:0] fifth;
        logic [INTV_W-1:0] seventh;
        third   = 4'd4;
        fifth   = 4'd7;
        seventh = 4'd0;
        case (q)
            Q_DIM:     begin third = 4'd3; fifth = 4'd6; end
            Q_MIN:     begin third = 4'd3; fifth = 4'd7; end
            Q_MAJ:     begin third = 4'd4; fifth = 4'd7; end
            Q_AUG:     begin third = 4'd4; fifth = 4'd8; end
            Q_FULLDIM: begin third = 4'd3; fifth = 4'd6; seventh = 4'd9;  end
            Q_HALFDIM: begin third = 4'd3; fifth = 4'd6; seventh = 4'd10; end
            Q_MM7:     begin third = 4'd3; fifth = 4'd7; seventh = 4'd10; end
            Q_MMAJ7:   begin third = 4'd3; fifth = 4'd7; seventh = 4'd11; end
            Q_DOM7:    begin third = 4'd4; fifth = 4'd7; seventh = 4'd10; end
            Q_MAJ7:    begin third = 4'd4; fifth = 4'd7; seventh = 4'd11; end
            default:   begin third = 4'd0; fifth = 4'd0; end
        endcase
        case (i)
            2'd0:    interval_of = 4'd0;
            2'd1:    interval_of = third;
            2'd2:    interval_of = fifth;
            default: interval_of = seventh;
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] tone_count_of(input logic [QUAL_W-1:0] q);
        case (q)
            Q_DIM, Q_MIN, Q_MAJ, Q_AUG: tone_count_of = 3'd3;
            default:                    tone_count_of = 3'd4;
        endcase
    endfunction

endpackage

>>> rtl/core/mca_event_if.sv
// Input channel of the chord arpeggiator: one timed note event per transaction.
// Depends on mca_pkg.
interface mca_event_if import mca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [KEY_W-1:0]  key_number;
    logic [VEL_W-1:0]  velocity;
    logic [TIME_W-1:0] event_time;

    modport source (output valid, mode, key_number, velocity, event_time, input ready);
    modport sink   (input valid, mode, key_number, velocity, event_time, output ready);
endinterface

>>> rtl/core/mca_tone_if.sv
// Output channel of the chord arpeggiator: one scheduled chord tone per transaction.
// Depends on mca_pkg.
interface mca_tone_if import mca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  tone_key;
    logic [VEL_W-1:0]  tone_velocity;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] tone_length;
    logic              last_tone;

    modport source (output valid, tone_key, tone_velocity, start_time, tone_length,
                    last_tone, input ready);
    modport sink   (input valid, tone_key, tone_velocity, start_time, tone_length,
                    last_tone, output ready);
endinterface

>>> rtl/core/midi_chord_arpeggiator_unit.sv
// MIDI chord arpeggiator. One note event is taken per transaction on the events
// channel, and the block then stays busy until the event is fully handled: a
// note-on that plays a chord first forms the base time (S_BASE) and then emits
// the tones of its 3- or 4-tone chord in turn (S_TONE), holding while the tones
// channel stalls; a note-on recorded in a session passes through S_REC_ON, a
// note-off in a session through S_OFF_FIND and, on a match, S_OFF_DUR; every
// other event is handled in S_IDLE. The single shared 32-bit adder forms every
// start time, onset and duration in turn. Results leave through an output
// register, so a new event is taken while the final tone of a chord still waits
// on the tones channel. Configuration writes land directly in the quality and
// offset registers; there is no reset sweep. Depends on mca_pkg, mca_event_if,
// mca_tone_if, mca_alu and mca_tone_store.
module midi_chord_arpeggiator_unit import mca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mca_event_if.sink             events,
    mca_tone_if.source            tones,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_BASE     = 6'b000010,
        S_TONE     = 6'b000100,
        S_REC_ON   = 6'b001000,
        S_OFF_FIND = 6'b010000,
        S_OFF_DUR  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Latched event fields.
    logic [KEY_W-1:0]  key_reg;
    logic [VEL_W-1:0]  vel_reg;
    logic [TIME_W-1:0] time_reg;

    // Configuration registers.
    logic [QUAL_W-1:0] quality_reg;
    logic [OFFS_W-1:0] offset_reg;

    // Session state.
    logic               rec_reg, rec_next;
    logic [COUNT_W-1:0] on_count_reg, on_count_next;
    logic [COUNT_W-1:0] off_count_reg, off_count_next;
    logic [TIME_W-1:0]  ss_reg;

    // Working registers of the sequencer.
    logic [IDX_W-1:0]  tone_idx_reg, tone_idx_next;
    logic [TIME_W-1:0] base_reg;
    logic [TIME_W-1:0] acc_reg;
    logic [IDX_W-1:0]  match_idx_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]  out_key_reg;
    logic [VEL_W-1:0]  out_vel_reg;
    logic [TIME_W-1:0] out_start_reg;
    logic [TIME_W-1:0] out_len_reg;
    logic              out_last_reg;

    alu_op_t           alu_op;
    logic [TIME_W-1:0] alu_result;
    store_wr_t         st_wr;
    store_rd_t         st_rd;
    logic [IDX_W-1:0]  st_rd_idx;
    logic              st_hit;
    logic [IDX_W-1:0]  st_hit_idx;

    logic               ev_accept;
    logic [COUNT_W-1:0] tone_count;
    logic [IDX_W-1:0]   next_idx;
    logic [KEY_W:0]     key_sum_cur;
    logic [KEY_W:0]     key_sum_nxt;
    logic               tone_is_last;
    logic               can_load;
    logic               tone_load;
    logic [TIME_W-1:0]  offset_ext;
    logic [TIME_W-1:0]  ss_use;

    mca_alu u_alu
    (
        .op     (alu_op),
        .result (alu_result)
    );

    mca_tone_store u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (st_wr),
        .rd_idx      (st_rd_idx),
        .rd          (st_rd),
        .match_key   (key_reg),
        .match_limit (on_count_reg),
        .match_hit   (st_hit),
        .match_idx   (st_hit_idx)
    );

    assign events.ready = (state_reg == S_IDLE);
    assign ev_accept    = events.valid && events.ready;

    assign offset_ext = {{(TIME_W-OFFS_W){offset_reg[OFFS_W-1]}}, offset_reg};

    // The first captured note of a session defines the session start time.
    assign ss_use = (on_count_reg == '0) ? time_reg : ss_reg;

    // Chord tone bookkeeping. Intervals rise within a chord, so once a tone
    // falls above the top key, every later tone does too, and the current
    // tone is the last one emitted.
    assign tone_count  = tone_count_of(quality_reg);
    assign next_idx    = tone_idx_reg + IDX_W'(1);
    assign key_sum_cur = {1'b0, key_reg} + (KEY_W+1)'(interval_of(quality_reg, tone_idx_reg));
    assign key_sum_nxt = {1'b0, key_reg} + (KEY_W+1)'(interval_of(quality_reg, next_idx));
    assign tone_is_last = ({1'b0, tone_idx_reg} == (tone_count - COUNT_W'(1)))
                          || key_sum_nxt[KEY_W];

    assign can_load  = !out_valid_reg || tones.ready;
    assign tone_load = (state_reg == S_TONE) && can_load;

    // During the note-off search the store reads at the matching entry.
    assign st_rd_idx = (state_reg == S_TONE) ? tone_idx_reg : st_hit_idx;

    always_comb
    begin
        state_next     = state_reg;
        rec_next       = rec_reg;
        on_count_next  = on_count_reg;
        off_count_next = off_count_reg;
        tone_idx_next  = tone_idx_reg;
        alu_op         = '{a: time_reg, b: offset_ext, sub: 1'b0};
        st_wr          = '0;
        st_wr.rec_idx  = on_count_reg[IDX_W-1:0];
        st_wr.rec_key  = key_reg;
        st_wr.rec_attack = vel_reg;
        st_wr.off_idx  = match_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (ev_accept)
                begin
                    if (events.mode)
                    begin
                        // A session start, also when one is running.
                        rec_next       = 1'b1;
                        on_count_next  = '0;
                        off_count_next = '0;
                        st_wr.fin_clr  = 1'b1;
                    end
                    else if (rec_reg)
                    begin
                        if (events.velocity != '0)
                        begin
                            // A fifth note-on in a session is dropped.
                            if (!on_count_reg[COUNT_W-1])
                            begin
                                state_next = S_REC_ON;
                            end
                        end
                        else
                        begin
                            state_next = S_OFF_FIND;
                        end
                    end
                    else if ((events.velocity != '0) && (quality_reg < QUAL_W'(NUM_QUALITIES)))
                    begin
                        state_next = S_BASE;
                    end
                end
            end

            S_BASE:
            begin
                // Base time is the event time plus the signed offset.
                alu_op        = '{a: time_reg, b: offset_ext, sub: 1'b0};
                tone_idx_next = '0;
                state_next    = S_TONE;
            end

            S_TONE:
            begin
                alu_op = '{a: base_reg, b: st_rd.onset, sub: 1'b0};
                if (can_load)
                begin
                    if (tone_is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tone_idx_next = next_idx;
                    end
                end
            end

            S_REC_ON:
            begin
                alu_op          = '{a: time_reg, b: ss_use, sub: 1'b1};
                st_wr.rec_we    = 1'b1;
                st_wr.rec_onset = alu_result;
                on_count_next   = on_count_reg + COUNT_W'(1);
                if (on_count_next[COUNT_W-1] && off_count_reg[COUNT_W-1])
                begin
                    rec_next = 1'b0;
                end
                state_next = S_IDLE;
            end

            S_OFF_FIND:
            begin
                // Time since the matched onset; the session start follows.
                alu_op = '{a: time_reg, b: st_rd.onset, sub: 1'b1};
                if (st_hit)
                begin
                    state_next = S_OFF_DUR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_OFF_DUR:
            begin
                alu_op         = '{a: acc_reg, b: ss_reg, sub: 1'b1};
                st_wr.off_we   = 1'b1;
                st_wr.off_dur  = alu_result;
                off_count_next = off_count_reg + COUNT_W'(1);
                if (on_count_reg[COUNT_W-1] && off_count_next[COUNT_W-1])
                begin
                    rec_next = 1'b0;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (tone_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (tones.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rec_reg       <= 1'b0;
            on_count_reg  <= '0;
            off_count_reg <= '0;
            tone_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            quality_reg   <= Q_MAJ;
            offset_reg    <= '0;
            ss_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rec_reg       <= rec_next;
            on_count_reg  <= on_count_next;
            off_count_reg <= off_count_next;
            tone_idx_reg  <= tone_idx_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == S_REC_ON) && (on_count_reg == '0))
            begin
                ss_reg <= time_reg;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHORD_QUALITY: quality_reg <= cfg_data[QUAL_W-1:0];
                    CFG_TIMING_OFFSET: offset_reg  <= cfg_data[OFFS_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ev_accept)
        begin
            key_reg  <= events.key_number;
            vel_reg  <= events.velocity;
            time_reg <= events.event_time;
        end
        if (state_reg == S_BASE)
        begin
            base_reg <= alu_result;
        end
        if (state_reg == S_OFF_FIND)
        begin
            acc_reg       <= alu_result;
            match_idx_reg <= st_hit_idx;
        end
        if (tone_load)
        begin
            out_key_reg   <= key_sum_cur[KEY_W-1:0];
            out_vel_reg   <= (st_rd.attack != '0) ? st_rd.attack : vel_reg;
            out_start_reg <= alu_result;
            out_len_reg   <= st_rd.dur;
            out_last_reg  <= tone_is_last;
        end
    end

    assign tones.valid         = out_valid_reg;
    assign tones.tone_key      = out_key_reg;
    assign tones.tone_velocity = out_vel_reg;
    assign tones.start_time    = out_start_reg;
    assign tones.tone_length   = out_len_reg;
    assign tones.last_tone     = out_last_reg;

endmodule

>>> rtl/core/mca_alu.sv
// Shared 32-bit adder/subtractor used by the sequencer for every time sum.
// Depends on mca_pkg.
module mca_alu import mca_pkg::*;
(
    input  alu_op_t           op,
    output logic [TIME_W-1:0] result
);

    logic [TIME_W-1:0] b_eff;

    // Subtraction is a plus the ones' complement of b plus one.
    assign b_eff  = op.sub ? ~op.b : op.b;
    assign result = op.a + b_eff + {{(TIME_W-1){1'b0}}, op.sub};

endmodule

>>> rtl/core/mca_tone_store.sv
// Per-tone parameter store (onsets, durations, attacks, captured keys) with the
// note-off match search. Depends on mca_pkg.
module mca_tone_store import mca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  store_wr_t          wr,
    input  logic [IDX_W-1:0]   rd_idx,
    output store_rd_t          rd,
    input  logic [KEY_W-1:0]   match_key,
    input  logic [COUNT_W-1:0] match_limit,
    output logic               match_hit,
    output logic [IDX_W-1:0]   match_idx
);

    logic [TIME_W-1:0] onset_reg  [CHORD_TONES];
    logic [TIME_W-1:0] dur_reg    [CHORD_TONES];
    logic [VEL_W-1:0]  attack_reg [CHORD_TONES];
    logic [KEY_W-1:0]  key_reg    [CHORD_TONES];
    logic [CHORD_TONES-1:0] fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHORD_TONES; i++)
            begin
                onset_reg[i]  <= TIME_W'(i * ONSET_STEP);
                dur_reg[i]    <= TIME_W'(DUR_FIRST - i * ONSET_STEP);
                attack_reg[i] <= '0;
                key_reg[i]    <= '0;
            end
            fin_reg <= '0;
        end
        else
        begin
            if (wr.rec_we)
            begin
                onset_reg[wr.rec_idx]  <= wr.rec_onset;
                attack_reg[wr.rec_idx] <= wr.rec_attack;
                key_reg[wr.rec_idx]    <= wr.rec_key;
            end
            if (wr.off_we)
            begin
                dur_reg[wr.off_idx] <= wr.off_dur;
            end
            if (wr.fin_clr)
            begin
                fin_reg <= '0;
            end
            else if (wr.off_we)
            begin
                fin_reg[wr.off_idx] <= 1'b1;
            end
        end
    end

    assign rd.onset  = onset_reg[rd_idx];
    assign rd.dur    = dur_reg[rd_idx];
    assign rd.attack = attack_reg[rd_idx];

    // The first captured, unfinished entry below the capture count wins.
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = CHORD_TONES - 1; i >= 0; i--)
        begin
            if ((COUNT_W'(i) < match_limit) && (key_reg[i] == match_key) && !fin_reg[i])
            begin
                match_hit = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

endmodule

>>> rtl/core/mca_checker.sv
// Port-level checker of the chord arpeggiator and its bind to the top level.
// Depends on mca_pkg and midi_chord_arpeggiator_unit_defines.svh.
`include "midi_chord_arpeggiator_unit_defines.svh"

module mca_checker import mca_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              ev_ready,
    input logic              tn_valid,
    input logic              tn_ready,
    input logic [TIME_W-1:0] tn_start_time,
    input logic              tn_last_tone
);

    // A stalled tone keeps its start time.
    `MCA_ASSERT_NEXT(a_tone_hold, clk, rst_n, tn_valid && !tn_ready, tn_valid && $stable(tn_start_time))

    // A chord in progress delivers its next tone right after each transaction.
    `MCA_ASSERT_NEXT(a_chord_dense, clk, rst_n, tn_valid && tn_ready && !tn_last_tone, tn_valid)

    // No new event is taken while a chord still has tones to come.
    `MCA_ASSERT_SAME(a_busy_in_chord, clk, rst_n, tn_valid && tn_ready && !tn_last_tone, !ev_ready)

endmodule

bind midi_chord_arpeggiator_unit mca_checker u_mca_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_ready      (events.ready),
    .tn_valid      (tones.valid),
    .tn_ready      (tones.ready),
    .tn_start_time (tones.start_time),
    .tn_last_tone  (tones.last_tone)
);
